[rtl/smoothed_peak_rate_counter_top_assert.svh]
// Assertion macros shared by the smoothed peak rate counter modules.
// Both sample on clk and are disabled while rst_n is low.
`ifndef SMOOTHED_PEAK_RATE_COUNTER_TOP_ASSERT_SVH
`define SMOOTHED_PEAK_RATE_COUNTER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SPR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smoothed peak rate counter: assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define SPR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smoothed peak rate counter: assertion failed");

`endif

[rtl/spr_pkg.sv]
`timescale 1ns / 1ps

package spr_pkg;

    // Parameter defaults
    localparam int MAX_WINDOW_DEF = 8;
    localparam int MAX_RECORD_DEF = 65535;

    // Field widths
    localparam int SAMPLE_W   = 16;
    localparam int WIN_CFG_W  = 4;
    localparam int THR_W      = 16;
    localparam int REFR_W     = 10;
    localparam int RATE_HZ_W  = 12;
    localparam int PEAKS_W    = 16;
    localparam int RATE_W     = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 64;

    // Rate scaling: hundredths of bpm per peak per hertz
    localparam int CENTI_BPM_SCALE = 6000;
    localparam int SCALE_W  = 13;
    localparam int SCALED_W = RATE_HZ_W + SCALE_W;
    localparam int NUM_W    = PEAKS_W + SCALED_W;

    // Offset that maps a signed sample onto an unsigned value
    localparam int SAMPLE_OFFSET = 32768;

    localparam logic [PEAKS_W-1:0] PEAKS_MAX = '1;
    localparam logic [RATE_W-1:0]  RATE_MAX  = '1;

    // Register reset values
    localparam logic [WIN_CFG_W-1:0]    WIN_RST  = 4'd8;
    localparam logic signed [THR_W-1:0] THR_RST  = 16'sd1638;
    localparam logic [REFR_W-1:0]       REFR_RST = 10'd100;
    localparam logic [RATE_HZ_W-1:0]    RATE_RST = 12'd250;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_WINDOW_LENGTH  = 2'd0,
        CFG_PEAK_THRESHOLD = 2'd1,
        CFG_REFRACTORY     = 2'd2,
        CFG_SAMPLE_RATE    = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [WIN_CFG_W-1:0]    window_length;
        logic signed [THR_W-1:0] peak_threshold;
        logic [REFR_W-1:0]       refractory_samples;
        logic [RATE_HZ_W-1:0]    sample_rate_hz;
    } cfg_t;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SUM,
        ST_MUL,
        ST_FIX,
        ST_RMUL,
        ST_RPROD,
        ST_RDIV,
        ST_OUT
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic sum;
        logic mul;
        logic fix;
        logic rmul;
        logic div_start;
        logic out_load;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last;
        logic div_done;
        logic out_free;
    } status_t;

endpackage

[rtl/smoothed_peak_rate_counter_top.sv]
// Flow: an accepted sample passes the controller states SUM, MUL and FIX (sum, multiply,
// correct), and its result is loaded into the output register in OUT; a record's last
// sample also runs the rate multiply and divide (RMUL, RPROD, RDIV) before OUT. OUT waits
// while the output register is still full, and a new sample is accepted only in IDLE.
// Reset (rst_n low, asynchronous): registers return to their defaults, record
// state and the output valid flag are cleared; the block is ready at once.
`timescale 1ns / 1ps

module smoothed_peak_rate_counter_top #(
    parameter int MAX_WINDOW = spr_pkg::MAX_WINDOW_DEF,
    parameter int MAX_RECORD = spr_pkg::MAX_RECORD_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Configuration write port
    input  logic                                cfg_we,
    input  logic [spr_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0]      cfg_data,
    // Sample stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [spr_pkg::IN_TDATA_W-1:0]      s_axis_tdata,   // [15:0] sample
    input  logic                                s_axis_tlast,   // last_sample
    // Result stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [spr_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,   // [15:0] smoothed,
                                                                // [16] peak_found,
                                                                // [32:17] peak_count,
                                                                // [56:33] rate_centi_bpm,
                                                                // [63:57] zero
    output logic                                m_axis_tlast    // record_end
);

    localparam int USED_W = 2 * spr_pkg::SAMPLE_W + 1 + spr_pkg::RATE_W;

    spr_pkg::cfg_t    cfg;
    spr_pkg::cmd_t    cmd;
    spr_pkg::status_t status;

    logic signed [spr_pkg::SAMPLE_W-1:0] smoothed;
    logic                                peak_found;
    logic [spr_pkg::PEAKS_W-1:0]         peak_count;
    logic [spr_pkg::RATE_W-1:0]          rate_centi_bpm;

    spr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    spr_dp #(
        .MAX_WINDOW (MAX_WINDOW),
        .MAX_RECORD (MAX_RECORD)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .cfg            (cfg),
        .sample         (signed'(s_axis_tdata[spr_pkg::SAMPLE_W-1:0])),
        .last_sample    (s_axis_tlast),
        .out_ready      (m_axis_tready),
        .out_valid      (m_axis_tvalid),
        .smoothed       (smoothed),
        .peak_found     (peak_found),
        .peak_count     (peak_count),
        .rate_centi_bpm (rate_centi_bpm),
        .record_end     (m_axis_tlast)
    );

    // Result packing, first field in the low bits
    assign m_axis_tdata = {{(spr_pkg::OUT_TDATA_W - USED_W){1'b0}},
                           rate_centi_bpm, peak_count, peak_found, smoothed};

endmodule

[rtl/spr_cfg.sv]
`timescale 1ns / 1ps

module spr_cfg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [spr_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [spr_pkg::CFG_DATA_W-1:0]     cfg_data,
    output spr_pkg::cfg_t                      cfg
);

    spr_pkg::cfg_t cfg_reg;
    spr_pkg::cfg_t cfg_next;

    // Register write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (spr_pkg::cfg_idx_t'(cfg_index))
                spr_pkg::CFG_WINDOW_LENGTH:
                    cfg_next.window_length = cfg_data[spr_pkg::WIN_CFG_W-1:0];
                spr_pkg::CFG_PEAK_THRESHOLD:
                    cfg_next.peak_threshold = signed'(cfg_data[spr_pkg::THR_W-1:0]);
                spr_pkg::CFG_REFRACTORY:
                    cfg_next.refractory_samples = cfg_data[spr_pkg::REFR_W-1:0];
                spr_pkg::CFG_SAMPLE_RATE:
                    cfg_next.sample_rate_hz = cfg_data[spr_pkg::RATE_HZ_W-1:0];
                default:
                    cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.window_length      <= spr_pkg::WIN_RST;
            cfg_reg.peak_threshold     <= spr_pkg::THR_RST;
            cfg_reg.refractory_samples <= spr_pkg::REFR_RST;
            cfg_reg.sample_rate_hz     <= spr_pkg::RATE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[rtl/spr_div.sv]
`timescale 1ns / 1ps

// Restoring divider, one quotient bit per cycle, MSB first.
module spr_div #(
    parameter int NUM_W = spr_pkg::NUM_W,
    parameter int DEN_W = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output logic             done
);

    localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

    logic             busy_reg,  busy_next;
    logic             done_reg,  done_next;
    logic [CNT_W-1:0] cnt_reg,   cnt_next;
    logic [NUM_W-1:0] quo_reg,   quo_next;
    logic [DEN_W-1:0] rem_reg,   rem_next;
    logic [DEN_W-1:0] den_reg,   den_next;
    logic [DEN_W:0]   trial;
    logic             ge;

    // One shift-subtract step
    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        ge    = (trial >= {1'b0, den_reg});
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(NUM_W - 1);
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg)
        begin
            quo_next = {quo_reg[NUM_W-2:0], ge};
            rem_next = ge ? DEN_W'(trial - {1'b0, den_reg}) : trial[DEN_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control flops
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Operand flops
    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign quo  = quo_reg;
    assign done = done_reg;

endmodule

[rtl/spr_dp.sv]
`timescale 1ns / 1ps
`include "smoothed_peak_rate_counter_top_assert.svh"

module spr_dp #(
    parameter int MAX_WINDOW = spr_pkg::MAX_WINDOW_DEF,
    parameter int MAX_RECORD = spr_pkg::MAX_RECORD_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  spr_pkg::cmd_t                        cmd,
    output spr_pkg::status_t                     status,
    input  spr_pkg::cfg_t                        cfg,
    input  logic signed [spr_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                 last_sample,
    input  logic                                 out_ready,
    output logic                                 out_valid,
    output logic signed [spr_pkg::SAMPLE_W-1:0]  smoothed,
    output logic                                 peak_found,
    output logic [spr_pkg::PEAKS_W-1:0]          peak_count,
    output logic [spr_pkg::RATE_W-1:0]           rate_centi_bpm,
    output logic                                 record_end
);

    localparam int SW   = spr_pkg::SAMPLE_W;
    localparam int CW   = $clog2(MAX_WINDOW + 1);
    localparam int IW   = $clog2(MAX_RECORD + 1);
    localparam int UW   = SW + CW;
    localparam int SUMW = UW + 1;
    localparam int RW   = UW + 1;
    localparam int PW   = UW + RW;
    localparam int QW   = SW + 1;
    localparam int NW   = spr_pkg::NUM_W;
    localparam int RTW  = spr_pkg::RATE_W;

    // Record state
    logic signed [SW-1:0]           hist_reg [MAX_WINDOW];
    logic [IW-1:0]                  idx_reg,   idx_next;
    logic signed [SW-1:0]           prev0_reg, prev0_next;
    logic signed [SW-1:0]           prev1_reg, prev1_next;
    logic [spr_pkg::REFR_W-1:0]     refr_reg,  refr_next;
    logic [spr_pkg::PEAKS_W-1:0]    peaks_reg, peaks_next;
    logic                           last_reg;

    // Per-item working registers
    logic [CW-1:0]                  cnt_reg;
    logic [UW-1:0]                  u_reg;
    logic [RW-1:0]                  recip_reg;
    logic [PW-1:0]                  prod_reg;
    logic signed [SW-1:0]           sm_reg;
    logic                           peak_reg;
    logic [spr_pkg::SCALED_W-1:0]   scaled_reg;

    // Output register
    logic                           out_valid_reg;
    logic signed [SW-1:0]           out_sm_reg;
    logic                           out_peak_reg;
    logic [spr_pkg::PEAKS_W-1:0]    out_count_reg;
    logic [RTW-1:0]                 out_rate_reg;
    logic                           out_last_reg;

    logic [CW-1:0]                  win;
    logic [CW-1:0]                  cnt_next;
    logic signed [SUMW-1:0]         sum_acc;
    logic [UW-1:0]                  u_next;
    logic [RW-1:0]                  recip_tab [MAX_WINDOW + 1];
    logic [QW-1:0]                  q_est;
    logic [UW:0]                    qc;
    logic [UW:0]                    rem_w;
    logic [QW-1:0]                  q_fix;
    logic signed [SW-1:0]           sm_new;
    logic signed [SW-1:0]           thr;
    logic                           cand;
    logic                           peak_hit;
    logic [NW-1:0]                  num_a;
    logic [NW-1:0]                  num_b;
    logic [NW-1:0]                  div_quo;
    logic                           div_done;
    logic                           rate_ok;
    logic [RTW-1:0]                 rate_sat;

    // Reciprocal table, floor(2^UW / c)
    assign recip_tab[0] = '0;
    for (genvar g = 1; g <= MAX_WINDOW; g++)
    begin : g_recip
        localparam logic [RW-1:0] RECIP_VAL = RW'((64'd1 << UW) / g);
        assign recip_tab[g] = RECIP_VAL;
    end

    // Effective window and averaging count
    always_comb
    begin
        if (cfg.window_length == '0)
            win = CW'(1);
        else if (int'(cfg.window_length) > MAX_WINDOW)
            win = CW'(MAX_WINDOW);
        else
            win = CW'(cfg.window_length);
        if (int'(idx_reg) < int'(win))
            cnt_next = CW'(int'(idx_reg) + 1);
        else
            cnt_next = win;
    end

    // Masked window sum, offset to a non-negative value
    always_comb
    begin
        sum_acc = '0;
        for (int k = 0; k < MAX_WINDOW; k++)
        begin
            if (k < int'(cnt_reg))
                sum_acc = sum_acc + SUMW'(hist_reg[k]);
        end
        u_next = UW'(sum_acc + (SUMW'(cnt_reg) << (SW - 1)));
    end

    // Quotient correction and back to signed
    always_comb
    begin
        q_est  = prod_reg[UW +: QW];
        qc     = (UW + 1)'(q_est) * (UW + 1)'(cnt_reg);
        rem_w  = {1'b0, u_reg} - qc;
        q_fix  = q_est + QW'(rem_w >= (UW + 1)'(cnt_reg));
        sm_new = signed'(SW'(q_fix - QW'(spr_pkg::SAMPLE_OFFSET)));
    end

    // Peak candidate test
    always_comb
    begin
        thr        = cfg.peak_threshold;
        cand       = (idx_reg >= IW'(2));
        peak_hit   = 1'b0;
        refr_next  = refr_reg;
        peaks_next = peaks_reg;
        if (cand)
        begin
            if (refr_reg != '0)
            begin
                refr_next = refr_reg - 1'b1;
            end
            else if ((prev0_reg > prev1_reg) && (prev0_reg > sm_new) && (prev0_reg > thr))
            begin
                peak_hit  = 1'b1;
                refr_next = cfg.refractory_samples;
                if (peaks_reg != spr_pkg::PEAKS_MAX)
                    peaks_next = peaks_reg + 1'b1;
            end
        end
        prev1_next = prev0_reg;
        prev0_next = sm_new;
        idx_next   = (int'(idx_reg) < MAX_RECORD) ? idx_reg + 1'b1 : idx_reg;
    end

    // Rate numerator operands
    assign num_a = NW'(peaks_reg);
    assign num_b = NW'(scaled_reg);

    spr_div #(
        .NUM_W (NW),
        .DEN_W (IW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.div_start),
        .num   (num_a * num_b),
        .den   (idx_reg),
        .quo   (div_quo),
        .done  (div_done)
    );

    // Rate result with short-record and overflow handling
    always_comb
    begin
        rate_ok  = (idx_reg >= IW'(3)) && (cfg.sample_rate_hz != '0);
        rate_sat = (div_quo[NW-1:RTW] != '0) ? spr_pkg::RATE_MAX : div_quo[RTW-1:0];
    end

    // Record state, cleared when the last sample's result is loaded into the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < MAX_WINDOW; k++)
                hist_reg[k] <= '0;
            idx_reg   <= '0;
            prev0_reg <= '0;
            prev1_reg <= '0;
            refr_reg  <= '0;
            peaks_reg <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                for (int k = MAX_WINDOW - 1; k > 0; k--)
                    hist_reg[k] <= hist_reg[k-1];
                hist_reg[0] <= sample;
                last_reg    <= last_sample;
            end
            if (cmd.fix)
            begin
                idx_reg   <= idx_next;
                prev0_reg <= prev0_next;
                prev1_reg <= prev1_next;
                refr_reg  <= refr_next;
                peaks_reg <= peaks_next;
            end
            if (cmd.out_load && last_reg)
            begin
                for (int k = 0; k < MAX_WINDOW; k++)
                    hist_reg[k] <= '0;
                idx_reg   <= '0;
                prev0_reg <= '0;
                prev1_reg <= '0;
                refr_reg  <= '0;
                peaks_reg <= '0;
            end
        end
    end

    // Arithmetic pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.load)
            cnt_reg <= cnt_next;
        if (cmd.sum)
        begin
            u_reg     <= u_next;
            recip_reg <= recip_tab[cnt_reg];
        end
        if (cmd.mul)
            prod_reg <= u_reg * recip_reg;
        if (cmd.fix)
        begin
            sm_reg   <= sm_new;
            peak_reg <= peak_hit;
        end
        if (cmd.rmul)
            scaled_reg <= spr_pkg::SCALED_W'(cfg.sample_rate_hz)
                          * spr_pkg::SCALED_W'(spr_pkg::CENTI_BPM_SCALE);
    end

    // Output register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // Output register payload
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_sm_reg    <= sm_reg;
            out_peak_reg  <= peak_reg;
            out_count_reg <= peaks_reg;
            out_rate_reg  <= (last_reg && rate_ok) ? rate_sat : '0;
            out_last_reg  <= last_reg;
        end
    end

    always_comb
    begin
        status.last     = last_reg;
        status.div_done = div_done;
        status.out_free = !out_valid_reg || out_ready;
    end

    assign out_valid      = out_valid_reg;
    assign smoothed       = out_sm_reg;
    assign peak_found     = out_peak_reg;
    assign peak_count     = out_count_reg;
    assign rate_centi_bpm = out_rate_reg;
    assign record_end     = out_last_reg;

    // Checks
    `SPR_ASSERT_NEXT(a_refr_countdown, cmd.fix && (idx_reg >= IW'(2)) && (refr_reg != '0), refr_reg == $past(refr_reg) - 1'b1)
    `SPR_ASSERT_NOW(a_peak_counted, out_valid_reg && out_peak_reg, out_count_reg != '0)
    `SPR_ASSERT_NOW(a_rate_on_end, out_valid_reg && (out_rate_reg != '0), out_last_reg)

endmodule

[rtl/spr_ctrl.sv]
`timescale 1ns / 1ps
`include "smoothed_peak_rate_counter_top_assert.svh"

module spr_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  spr_pkg::status_t  status,
    output spr_pkg::cmd_t     cmd
);

    spr_pkg::state_t state_reg;
    spr_pkg::state_t state_next;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spr_pkg::ST_IDLE:
                if (in_valid)
                    state_next = spr_pkg::ST_SUM;
            spr_pkg::ST_SUM:
                state_next = spr_pkg::ST_MUL;
            spr_pkg::ST_MUL:
                state_next = spr_pkg::ST_FIX;
            spr_pkg::ST_FIX:
                state_next = status.last ? spr_pkg::ST_RMUL : spr_pkg::ST_OUT;
            spr_pkg::ST_RMUL:
                state_next = spr_pkg::ST_RPROD;
            spr_pkg::ST_RPROD:
                state_next = spr_pkg::ST_RDIV;
            spr_pkg::ST_RDIV:
                if (status.div_done)
                    state_next = spr_pkg::ST_OUT;
            spr_pkg::ST_OUT:
                if (status.out_free)
                    state_next = spr_pkg::ST_IDLE;
            default:
                state_next = spr_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            spr_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            spr_pkg::ST_SUM:   cmd.sum       = 1'b1;
            spr_pkg::ST_MUL:   cmd.mul       = 1'b1;
            spr_pkg::ST_FIX:   cmd.fix       = 1'b1;
            spr_pkg::ST_RMUL:  cmd.rmul      = 1'b1;
            spr_pkg::ST_RPROD: cmd.div_start = 1'b1;
            spr_pkg::ST_RDIV:  cmd           = '0;
            spr_pkg::ST_OUT:   cmd.out_load  = status.out_free;
            default:           cmd           = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= spr_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Checks
    `SPR_ASSERT_NOW(a_cmd_single, 1'b1, $onehot0(cmd))
    `SPR_ASSERT_NEXT(a_load_then_sum, cmd.load, cmd.sum)
    `SPR_ASSERT_NOW(a_div_only_last, cmd.div_start, status.last)
    `SPR_ASSERT_NOW(a_done_in_wait, status.div_done, state_reg == spr_pkg::ST_RDIV)

endmodule

[sim/tb_smoothed_peak_rate_counter_top.sv]
`timescale 1ns / 1ps

module tb_smoothed_peak_rate_counter_top;

    localparam int WIN_MAX     = spr_pkg::MAX_WINDOW_DEF;
    localparam int RECORD_MAX  = spr_pkg::MAX_RECORD_DEF;
    localparam int CYCLE_LIMIT = 4_000_000;
    localparam int IDLE_PAUSE  = 8;
    localparam int END_PAUSE   = 64;
    localparam int REPORT_MAX  = 10;
    localparam int LONG_LEN    = 120;

    // One result transaction, split into its fields
    typedef struct packed {
        logic                                record_end;
        logic [spr_pkg::RATE_W-1:0]          rate_centi_bpm;
        logic [spr_pkg::PEAKS_W-1:0]         peak_count;
        logic                                peak_found;
        logic signed [spr_pkg::SAMPLE_W-1:0] smoothed;
    } beat_result_t;

    logic                            clk;
    logic                            rst_n;
    logic                            cfg_we;
    logic [spr_pkg::CFG_IDX_W-1:0]   cfg_index;
    logic [spr_pkg::CFG_DATA_W-1:0]  cfg_data;
    logic                            s_axis_tvalid;
    logic                            s_axis_tready;
    logic [spr_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
    logic                            s_axis_tlast;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [spr_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
    logic                            m_axis_tlast;

    // Shadow registers
    logic [spr_pkg::WIN_CFG_W-1:0]    win_cfg;
    logic signed [spr_pkg::THR_W-1:0] thr_cfg;
    logic [spr_pkg::REFR_W-1:0]       refr_cfg;
    logic [spr_pkg::RATE_HZ_W-1:0]    hz_cfg;

    // Shadow record state
    logic signed [spr_pkg::SAMPLE_W-1:0] hist_samples [WIN_MAX];
    int                                  seen_count;
    logic signed [spr_pkg::SAMPLE_W-1:0] sm_last;
    logic signed [spr_pkg::SAMPLE_W-1:0] sm_prior;
    int                                  skip_left;
    int                                  peak_total;

    beat_result_t expected_beats [$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    int           src_idle_pct   = 0;
    int           snk_stall_pct  = 0;

    smoothed_peak_rate_counter_top i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),   // [15:0] sample
        .s_axis_tlast  (s_axis_tlast),   // last_sample
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),   // [15:0] smoothed, [16] peak_found,
                                         // [32:17] peak_count, [56:33] rate_centi_bpm,
                                         // [63:57] zero
        .m_axis_tlast  (m_axis_tlast)    // record_end
    );

    // Clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results pending",
                     cycle_count, expected_beats.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Clear the per-record shadow state
    function automatic void clear_record_state();
        for (int k = 0; k < WIN_MAX; k++)
            hist_samples[k] = '0;
        seen_count = 0;
        sm_last    = '0;
        sm_prior   = '0;
        skip_left  = 0;
        peak_total = 0;
    endfunction

    // Expected result of one accepted sample; advances the shadow state
    function automatic void predict_beat(input logic signed [spr_pkg::SAMPLE_W-1:0] smp,
                                         input logic is_last);
        int              win;
        int              cnt;
        int              acc;
        int              avg;
        longint unsigned bpm;
        beat_result_t    res;

        win = int'(win_cfg);
        if (win < 1)
            win = 1;
        if (win > WIN_MAX)
            win = WIN_MAX;

        for (int k = WIN_MAX - 1; k > 0; k--)
            hist_samples[k] = hist_samples[k - 1];
        hist_samples[0] = smp;

        // Average over the samples present so far, rounded toward minus infinity
        cnt = (seen_count + 1 < win) ? seen_count + 1 : win;
        acc = 0;
        for (int k = 0; k < cnt; k++)
            acc += hist_samples[k];
        avg = acc / cnt;
        if ((acc % cnt) != 0 && acc < 0)
            avg -= 1;

        res = '0;
        res.smoothed = avg[spr_pkg::SAMPLE_W-1:0];

        // Previous smoothed value is the candidate; refractory span skips it
        if (seen_count >= 2)
        begin
            if (skip_left != 0)
                skip_left--;
            else if (sm_last > sm_prior && sm_last > res.smoothed && sm_last > thr_cfg)
            begin
                res.peak_found = 1'b1;
                if (peak_total < int'(spr_pkg::PEAKS_MAX))
                    peak_total++;
                skip_left = int'(refr_cfg);
            end
        end

        sm_prior = sm_last;
        sm_last  = res.smoothed;
        if (seen_count < RECORD_MAX)
            seen_count++;

        res.peak_count = peak_total[spr_pkg::PEAKS_W-1:0];
        res.record_end = is_last;

        if (is_last)
        begin
            if (seen_count >= 3 && hz_cfg != 0)
            begin
                bpm = longint'(peak_total) * longint'(spr_pkg::CENTI_BPM_SCALE)
                      * longint'(hz_cfg) / longint'(seen_count);
                res.rate_centi_bpm = (bpm > longint'(spr_pkg::RATE_MAX))
                                     ? spr_pkg::RATE_MAX : bpm[spr_pkg::RATE_W-1:0];
            end
            clear_record_state();
        end

        expected_beats.push_back(res);
    endfunction

    // Sender gap decision
    function automatic bit sender_gap();
        return $urandom_range(0, 99) < src_idle_pct;
    endfunction

    // Result checker and receiver backpressure
    always @(posedge clk)
    begin
        beat_result_t got;
        beat_result_t want;

        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.smoothed       = m_axis_tdata[15:0];
            got.peak_found     = m_axis_tdata[16];
            got.peak_count     = m_axis_tdata[32:17];
            got.rate_centi_bpm = m_axis_tdata[56:33];
            got.record_end     = m_axis_tlast;
            if (expected_beats.size() == 0)
            begin
                if (mismatch_count < REPORT_MAX)
                begin
                    $display("unexpected result: smoothed=%0d peak=%0b count=%0d",
                             got.smoothed, got.peak_found, got.peak_count);
                    $display("  rate=%0d end=%0b", got.rate_centi_bpm, got.record_end);
                end
                mismatch_count++;
            end
            else
            begin
                want = expected_beats.pop_front();
                if (got.smoothed !== want.smoothed || got.peak_found !== want.peak_found
                    || got.peak_count !== want.peak_count
                    || got.rate_centi_bpm !== want.rate_centi_bpm
                    || got.record_end !== want.record_end || m_axis_tdata[63:57] !== '0)
                begin
                    if (mismatch_count < REPORT_MAX)
                    begin
                        $display("mismatch at cycle %0d, pad=%h",
                                 cycle_count, m_axis_tdata[63:57]);
                        $display("  expected smoothed=%0d peak=%0b count=%0d rate=%0d end=%0b",
                                 want.smoothed, want.peak_found, want.peak_count,
                                 want.rate_centi_bpm, want.record_end);
                        $display("  actual   smoothed=%0d peak=%0b count=%0d rate=%0d end=%0b",
                                 got.smoothed, got.peak_found, got.peak_count,
                                 got.rate_centi_bpm, got.record_end);
                    end
                    mismatch_count++;
                end
            end
        end

        // Ready for the next cycle
        m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
    end

    // Send one sample transaction and record its expected result
    task automatic send_sample(input logic [spr_pkg::SAMPLE_W-1:0] smp, input logic is_last);
        while (sender_gap())
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= is_last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_beat(smp, is_last);
    endtask

    // Hold off the sender until every expected result has arrived
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (IDLE_PAUSE) @(posedge clk);
    endtask

    // Register write; only called while the block is idle
    task automatic cfg_write(input spr_pkg::cfg_idx_t idx,
                             input logic [spr_pkg::CFG_DATA_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            spr_pkg::CFG_WINDOW_LENGTH:  win_cfg  = val[spr_pkg::WIN_CFG_W-1:0];
            spr_pkg::CFG_PEAK_THRESHOLD: thr_cfg  = val[spr_pkg::THR_W-1:0];
            spr_pkg::CFG_REFRACTORY:     refr_cfg = val[spr_pkg::REFR_W-1:0];
            spr_pkg::CFG_SAMPLE_RATE:    hz_cfg   = val[spr_pkg::RATE_HZ_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_idling(input int src_pct, input int snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
    endtask

    // Full-scale samples, single and two-sample records
    task automatic test_extremes();
        wait_idle();
        cfg_write(spr_pkg::CFG_WINDOW_LENGTH, 16'd1);
        cfg_write(spr_pkg::CFG_PEAK_THRESHOLD, 16'h8000);
        cfg_write(spr_pkg::CFG_REFRACTORY, 16'd0);
        cfg_write(spr_pkg::CFG_SAMPLE_RATE, 16'd4095);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b1);
        // short records give no rate
        send_sample(16'd100, 1'b1);
        send_sample(16'd5, 1'b0);
        send_sample(16'd7, 1'b1);
    endtask

    // Window outside its range, zero rate, threshold limits, change within a record
    task automatic test_window_limits();
        wait_idle();
        cfg_write(spr_pkg::CFG_WINDOW_LENGTH, 16'd0);
        cfg_write(spr_pkg::CFG_SAMPLE_RATE, 16'd0);
        cfg_write(spr_pkg::CFG_PEAK_THRESHOLD, 16'h7FFF);
        send_sample(16'd0, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'd0, 1'b1);

        wait_idle();
        cfg_write(spr_pkg::CFG_WINDOW_LENGTH, 16'd15);
        cfg_write(spr_pkg::CFG_PEAK_THRESHOLD, 16'd0);
        cfg_write(spr_pkg::CFG_REFRACTORY, 16'd2);
        cfg_write(spr_pkg::CFG_SAMPLE_RATE, 16'd250);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'd8000, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd9000, 1'b0);

        // new settings take effect mid-record
        wait_idle();
        cfg_write(spr_pkg::CFG_WINDOW_LENGTH, 16'd3);
        cfg_write(spr_pkg::CFG_REFRACTORY, 16'd1023);
        cfg_write(spr_pkg::CFG_PEAK_THRESHOLD, 16'hFFFF);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd3000, 1'b0);
        send_sample(16'd0, 1'b0);
        send_sample(16'd0, 1'b1);
    endtask

    // Random settings, with junk in the unused data bits
    task automatic randomize_config();
        int sel;

        sel = $urandom_range(0, 19);
        if (sel < 3)
            cfg_write(spr_pkg::CFG_WINDOW_LENGTH,
                      16'($urandom_range(9, 15)) | (16'($urandom) & 16'hFFF0));
        else if (sel < 4)
            cfg_write(spr_pkg::CFG_WINDOW_LENGTH, 16'($urandom) & 16'hFFF0);
        else
            cfg_write(spr_pkg::CFG_WINDOW_LENGTH, 16'($urandom_range(1, 8)));

        sel = $urandom_range(0, 19);
        if (sel < 2)
            cfg_write(spr_pkg::CFG_PEAK_THRESHOLD, 16'($urandom));
        else if (sel < 3)
            cfg_write(spr_pkg::CFG_PEAK_THRESHOLD,
                      ($urandom_range(0, 1) != 0) ? 16'h7FFF : 16'h8000);
        else
            cfg_write(spr_pkg::CFG_PEAK_THRESHOLD, 16'($urandom_range(0, 5000)));

        sel = $urandom_range(0, 9);
        if (sel < 7)
            cfg_write(spr_pkg::CFG_REFRACTORY,
                      16'($urandom_range(0, 4)) | (16'($urandom) & 16'hFC00));
        else if (sel < 9)
            cfg_write(spr_pkg::CFG_REFRACTORY, 16'($urandom_range(5, 40)));
        else
            cfg_write(spr_pkg::CFG_REFRACTORY, 16'($urandom_range(41, 1023)));

        sel = $urandom_range(0, 9);
        if (sel == 0)
            cfg_write(spr_pkg::CFG_SAMPLE_RATE, 16'($urandom) & 16'hF000);
        else if (sel == 1)
            cfg_write(spr_pkg::CFG_SAMPLE_RATE, 16'd4095);
        else
            cfg_write(spr_pkg::CFG_SAMPLE_RATE,
                      16'($urandom_range(1, 4095)) | (16'($urandom) & 16'hF000));
    endtask

    // Pulse-train records mostly, some noise and short records
    task automatic test_random_records(input int n_items);
        int          sent;
        int          until_cfg;
        int          kind;
        int          rec_len;
        int          period;
        int          amp;
        int          base;
        int          v;
        logic [15:0] smp;

        sent      = 0;
        until_cfg = $urandom_range(20, 80);
        while (sent < n_items)
        begin
            kind    = $urandom_range(0, 9);
            period  = $urandom_range(3, 12);
            amp     = $urandom_range(1000, 32767);
            base    = $urandom_range(0, 600);
            if (kind == 0)
                rec_len = $urandom_range(1, 2);
            else if (kind < 3)
                rec_len = $urandom_range(3, 30);
            else
                rec_len = $urandom_range(3, 60);
            for (int k = 0; k < rec_len; k++)
            begin
                if (kind < 3)
                    smp = 16'($urandom);
                else
                begin
                    v = base + int'($urandom_range(0, 400)) - 200;
                    if (k % period == 0)
                        v += amp;
                    else if (k % period == 1)
                        v += amp / 3;
                    if (v > 32767)
                        v = 32767;
                    smp = v[15:0];
                end
                send_sample(smp, k == rec_len - 1);
                sent++;
                until_cfg--;
                // settings may change between records or mid-record
                if (until_cfg == 0)
                begin
                    wait_idle();
                    randomize_config();
                    until_cfg = $urandom_range(20, 80);
                end
            end
        end
    endtask

    // Long alternating record: a peak on every other sample at the top sample rate
    task automatic test_long_record();
        int n_samples;

        n_samples = LONG_LEN;
        wait_idle();
        cfg_write(spr_pkg::CFG_WINDOW_LENGTH, 16'd1);
        cfg_write(spr_pkg::CFG_PEAK_THRESHOLD, 16'h8000);
        cfg_write(spr_pkg::CFG_REFRACTORY, 16'd0);
        cfg_write(spr_pkg::CFG_SAMPLE_RATE, 16'd4095);
        for (int k = 0; k < n_samples; k++)
            send_sample((k % 2 != 0) ? 16'd1000 : 16'hFC18, k == n_samples - 1);
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= spr_pkg::CFG_WINDOW_LENGTH;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tlast  <= 1'b0;

        win_cfg  = spr_pkg::WIN_RST;
        thr_cfg  = spr_pkg::THR_RST;
        refr_cfg = spr_pkg::REFR_RST;
        hz_cfg   = spr_pkg::RATE_RST;
        clear_record_state();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_idling(10, 86);
        test_extremes();
        test_window_limits();
        test_random_records(180);

        set_idling(86, 10);
        test_random_records(180);

        set_idling(0, 0);
        test_random_records(180);
        test_long_record();

        wait_idle();
        repeat (END_PAUSE) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/spr_pkg.sv
rtl/spr_cfg.sv
rtl/spr_div.sv
rtl/spr_dp.sv
rtl/spr_ctrl.sv
rtl/smoothed_peak_rate_counter_top.sv
sim/tb_smoothed_peak_rate_counter_top.sv
